@@ hw/rtl/lmbcm_pkg.sv @@
// Package for the LED matrix BCM scan driver.
// Holds the command record passed front to back, opcodes, widths and the plane weight table.
// No dependencies.
package lmbcm_pkg;

    // default geometry
    localparam int PANEL_COLUMNS_DEF  = 64;
    localparam int ROW_PAIR_COUNT_DEF = 32;
    localparam int PLANE_COUNT_DEF    = 5;

    // fixed field widths of the stream items
    localparam int ROW_FW     = 5;
    localparam int COL_FW     = 6;
    localparam int COLOR_W    = 5;
    localparam int PIX_W      = 3 * COLOR_W;
    localparam int PLANE_FW   = 3;
    localparam int BASE_W     = 16;
    localparam int WEIGHT_W   = 4;
    localparam int ON_TIME_W  = 20;
    localparam int PINS_W     = 6;
    localparam int OPCODE_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // input opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE_PIXEL = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ROW_DONE    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START       = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_XFER_ERROR  = 2'd3;

    typedef enum logic {
        CMD_WRITE,
        CMD_RUN
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // one queued command: a pixel write or one column run
    typedef struct packed {
        t_cmd_kind              kind;
        logic                   bank;        // write: 1 = bottom half
        logic [ROW_FW-1:0]      row;         // write: bank row, run: row pair
        logic [COL_FW-1:0]      col;         // write only
        logic [PIX_W-1:0]       pixel;       // write only
        logic [PLANE_FW-1:0]    plane;       // run only
        logic                   shown_valid; // run only
        logic [ROW_FW-1:0]      shown_row;   // run only
        logic [ON_TIME_W-1:0]   on_time;     // run only
    } t_cmd;

    // BCM weight of each bitplane
    function automatic logic [WEIGHT_W-1:0] plane_weight(input logic [PLANE_FW-1:0] plane);
        logic [WEIGHT_W-1:0] w;
        case (plane)
            3'd0:    w = 4'd1;
            3'd1:    w = 4'd2;
            3'd2:    w = 4'd4;
            3'd3:    w = 4'd8;
            3'd4:    w = 4'd12;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/lmbcm_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lmbcm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lmbcm_front.sv @@
// Front end: accepts input beats, holds base time and scan counters, builds commands.
// Depends on lmbcm_pkg.
module lmbcm_front #(
    parameter int PANEL_COLUMNS  = lmbcm_pkg::PANEL_COLUMNS_DEF,
    parameter int ROW_PAIR_COUNT = lmbcm_pkg::ROW_PAIR_COUNT_DEF,
    parameter int PLANE_COUNT    = lmbcm_pkg::PLANE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lmbcm_pkg::BASE_W-1:0]        i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lmbcm_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [lmbcm_pkg::COL_FW-1:0]        i_pixel_x,
    input  logic [lmbcm_pkg::COL_FW-1:0]        i_pixel_y,
    input  logic [lmbcm_pkg::PIX_W-1:0]         i_pixel,
    input  logic                                i_clearing,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output lmbcm_pkg::t_cmd                     o_cmd
);

    logic [lmbcm_pkg::BASE_W-1:0]   r_base_time;
    logic [lmbcm_pkg::ROW_FW-1:0]   r_scan_row, n_scan_row;
    logic [lmbcm_pkg::PLANE_FW-1:0] r_scan_plane, n_scan_plane;

    logic                           accept;
    logic                           in_panel;
    logic                           bottom;
    logic [lmbcm_pkg::ROW_FW:0]     row_inc;
    logic [lmbcm_pkg::PLANE_FW:0]   plane_inc;
    logic [lmbcm_pkg::ON_TIME_W-1:0] on_time;

    assign o_ready = !i_clearing && !i_queue_full;
    assign accept  = i_valid && o_ready;

    assign in_panel = ({1'b0, i_pixel_x} < (lmbcm_pkg::COL_FW+1)'(PANEL_COLUMNS))
                   && ({1'b0, i_pixel_y} < (lmbcm_pkg::COL_FW+1)'(2 * ROW_PAIR_COUNT));
    assign bottom   = (i_pixel_y >= lmbcm_pkg::COL_FW'(ROW_PAIR_COUNT));

    // widen both factors so the product keeps all 20 bits
    assign on_time = lmbcm_pkg::ON_TIME_W'(lmbcm_pkg::plane_weight(r_scan_plane))
                   * lmbcm_pkg::ON_TIME_W'(r_base_time);

    // scan advance: row first, wrap into next plane
    always_comb begin
        row_inc      = {1'b0, r_scan_row} + 1'b1;
        plane_inc    = {1'b0, r_scan_plane} + 1'b1;
        n_scan_row   = row_inc[lmbcm_pkg::ROW_FW-1:0];
        n_scan_plane = r_scan_plane;
        if (row_inc >= (lmbcm_pkg::ROW_FW+1)'(ROW_PAIR_COUNT)) begin
            n_scan_row = '0;
            if (plane_inc >= (lmbcm_pkg::PLANE_FW+1)'(PLANE_COUNT)) begin
                n_scan_plane = '0;
            end else begin
                n_scan_plane = plane_inc[lmbcm_pkg::PLANE_FW-1:0];
            end
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        case (i_opcode)
            lmbcm_pkg::OP_WRITE_PIXEL: begin
                o_push     = accept && in_panel;
                o_cmd.kind = lmbcm_pkg::CMD_WRITE;
                o_cmd.bank = bottom;
                o_cmd.row  = bottom
                    ? lmbcm_pkg::ROW_FW'(i_pixel_y - lmbcm_pkg::COL_FW'(ROW_PAIR_COUNT))
                    : lmbcm_pkg::ROW_FW'(i_pixel_y);
                o_cmd.col   = i_pixel_x;
                o_cmd.pixel = i_pixel;
            end
            lmbcm_pkg::OP_ROW_DONE: begin
                o_push            = accept;
                o_cmd.kind        = lmbcm_pkg::CMD_RUN;
                o_cmd.row         = n_scan_row;
                o_cmd.plane       = n_scan_plane;
                o_cmd.shown_valid = 1'b1;
                o_cmd.shown_row   = r_scan_row;
                o_cmd.on_time     = on_time;
            end
            lmbcm_pkg::OP_START: begin
                o_push     = accept;
                o_cmd.kind = lmbcm_pkg::CMD_RUN;
            end
            default: begin
                o_push = 1'b0;   // transfer error is dropped
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_time  <= lmbcm_pkg::BASE_W'(1);
            r_scan_row   <= '0;
            r_scan_plane <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base_time <= i_cfg_wr_data;
            end
            if (accept && i_opcode == lmbcm_pkg::OP_ROW_DONE) begin
                r_scan_row   <= n_scan_row;
                r_scan_plane <= n_scan_plane;
            end
        end
    end

endmodule

@@ hw/rtl/lmbcm_queue.sv @@
// Short command FIFO between front and back.
// Depends on lmbcm_pkg.
module lmbcm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmbcm_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lmbcm_pkg::t_cmd o_cmd
);

    lmbcm_pkg::t_cmd                r_slot [lmbcm_pkg::QUEUE_DEPTH];
    logic [lmbcm_pkg::QUEUE_PTR_W-1:0] r_wptr, r_rptr;
    logic [lmbcm_pkg::QUEUE_PTR_W:0]   r_count;

    assign o_full  = (r_count == (lmbcm_pkg::QUEUE_PTR_W+1)'(lmbcm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue underflow");
`endif

endmodule

@@ hw/rtl/lmbcm_back.sv @@
// Back end: clears the frame store, applies pixel writes and streams column runs.
// Depends on lmbcm_pkg and lmbcm_ram.
module lmbcm_back #(
    parameter int PANEL_COLUMNS  = lmbcm_pkg::PANEL_COLUMNS_DEF,
    parameter int ROW_PAIR_COUNT = lmbcm_pkg::ROW_PAIR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  lmbcm_pkg::t_cmd                     i_q_cmd,
    output logic                                o_q_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lmbcm_pkg::PINS_W-1:0]        o_pins,
    output logic [lmbcm_pkg::COL_FW-1:0]        o_column,
    output logic                                o_display_valid,
    output logic [lmbcm_pkg::ROW_FW-1:0]        o_shown_row,
    output logic [lmbcm_pkg::ON_TIME_W-1:0]     o_on_time,
    output logic                                o_last
);

    localparam int ROW_W   = (ROW_PAIR_COUNT > 1) ? $clog2(ROW_PAIR_COUNT) : 1;
    localparam int COL_W   = $clog2(PANEL_COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_COLUMNS - 1);

    lmbcm_pkg::t_back_state r_state, n_state;

    logic [ADDR_W-1:0]              r_clr_addr;
    logic [ROW_W-1:0]               r_row;
    logic [COL_W-1:0]               r_col;
    logic [lmbcm_pkg::PLANE_FW-1:0] r_plane;
    logic                           r_sv;
    logic [lmbcm_pkg::ROW_FW-1:0]   r_srow;
    logic [lmbcm_pkg::ON_TIME_W-1:0] r_ontime;

    // read stage: data sits in the RAM output registers
    logic                           r_s1_valid;
    logic [COL_W-1:0]               r_s1_col;
    logic [lmbcm_pkg::PLANE_FW-1:0] r_s1_plane;
    logic                           r_s1_sv;
    logic [lmbcm_pkg::ROW_FW-1:0]   r_s1_srow;
    logic [lmbcm_pkg::ON_TIME_W-1:0] r_s1_ontime;

    // output register
    logic                           r_o_valid;
    logic [lmbcm_pkg::PINS_W-1:0]   r_o_pins;
    logic [COL_W-1:0]               r_o_col;
    logic                           r_o_sv;
    logic [lmbcm_pkg::ROW_FW-1:0]   r_o_srow;
    logic [lmbcm_pkg::ON_TIME_W-1:0] r_o_ontime;

    logic                           out_free;
    logic                           issue;
    logic                           pop;
    logic                           we_top, we_bot;
    logic [ADDR_W-1:0]              waddr;
    logic [lmbcm_pkg::PIX_W-1:0]    wdata;
    logic [ADDR_W-1:0]              raddr;
    logic [lmbcm_pkg::PIX_W-1:0]    q_top, q_bot;
    logic [3:0]                     bit_r, bit_g, bit_b;

    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lmbcm_pkg::BK_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = lmbcm_pkg::BK_IDLE;
                end
            end
            lmbcm_pkg::BK_IDLE: begin
                if (i_q_valid && i_q_cmd.kind == lmbcm_pkg::CMD_RUN) begin
                    n_state = lmbcm_pkg::BK_RUN;
                end
            end
            lmbcm_pkg::BK_RUN: begin
                if (issue && r_col == COL_LAST) begin
                    n_state = lmbcm_pkg::BK_IDLE;
                end
            end
            default: n_state = lmbcm_pkg::BK_CLEAR;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        issue      = 1'b0;
        we_top     = 1'b0;
        we_bot     = 1'b0;
        waddr      = {i_q_cmd.row[ROW_W-1:0], i_q_cmd.col[COL_W-1:0]};
        wdata      = i_q_cmd.pixel;
        o_clearing = 1'b0;
        case (r_state)
            lmbcm_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                we_top     = 1'b1;
                we_bot     = 1'b1;
                waddr      = r_clr_addr;
                wdata      = '0;
            end
            lmbcm_pkg::BK_IDLE: begin
                pop = i_q_valid;
                if (i_q_valid && i_q_cmd.kind == lmbcm_pkg::CMD_WRITE) begin
                    we_top = !i_q_cmd.bank;
                    we_bot = i_q_cmd.bank;
                end
            end
            lmbcm_pkg::BK_RUN: begin
                issue = !r_s1_valid || out_free;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    assign o_q_pop = pop;
    assign raddr   = {r_row, r_col};

    lmbcm_ram #(.WIDTH(lmbcm_pkg::PIX_W), .DEPTH(DEPTH)) u_ram_top (
        .i_clk   (i_clk),
        .i_we    (we_top),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (q_top)
    );

    lmbcm_ram #(.WIDTH(lmbcm_pkg::PIX_W), .DEPTH(DEPTH)) u_ram_bot (
        .i_clk   (i_clk),
        .i_we    (we_bot),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (q_bot)
    );

    // plane bit of each color, red at bit 0, green at 5, blue at 10
    assign bit_r = 4'(r_s1_plane);
    assign bit_g = 4'(r_s1_plane) + 4'd5;
    assign bit_b = 4'(r_s1_plane) + 4'd10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lmbcm_pkg::BK_CLEAR;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lmbcm_pkg::BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.kind == lmbcm_pkg::CMD_RUN) begin
            r_row    <= i_q_cmd.row[ROW_W-1:0];
            r_col    <= '0;
            r_plane  <= i_q_cmd.plane;
            r_sv     <= i_q_cmd.shown_valid;
            r_srow   <= i_q_cmd.shown_row;
            r_ontime <= i_q_cmd.on_time;
        end else if (issue) begin
            r_col <= r_col + 1'b1;
        end
        if (issue) begin
            r_s1_col    <= r_col;
            r_s1_plane  <= r_plane;
            r_s1_sv     <= r_sv;
            r_s1_srow   <= r_srow;
            r_s1_ontime <= r_ontime;
        end
        if (out_free && r_s1_valid) begin
            r_o_pins   <= {q_bot[bit_b], q_bot[bit_g], q_bot[bit_r],
                           q_top[bit_b], q_top[bit_g], q_top[bit_r]};
            r_o_col    <= r_s1_col;
            r_o_sv     <= r_s1_sv;
            r_o_srow   <= r_s1_srow;
            r_o_ontime <= r_s1_ontime;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pins          = r_o_pins;
    assign o_column        = lmbcm_pkg::COL_FW'(r_o_col);
    assign o_display_valid = r_o_sv;
    assign o_shown_row     = r_o_srow;
    assign o_on_time       = r_o_ontime;
    assign o_last          = (r_o_col == COL_LAST);

`ifndef ASSERT_OFF
    a_run_starts_at_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_q_cmd.kind == lmbcm_pkg::CMD_RUN) |=> (r_col == '0))
        else $error("run did not start at column zero");
    a_no_read_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_ready) |-> !issue)
        else $error("RAM read issued while read stage is blocked");
    a_no_cmd_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !pop && !r_o_valid)
        else $error("command handled during clearing pass");
    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_ready && o_last) |=> !(r_o_valid && r_o_col != '0 && $past(r_o_col) == COL_LAST && $changed(r_o_col)))
        else $error("run continued past its last column");
`endif

endmodule

@@ hw/rtl/led_matrix_bcm_scan_driver_core.sv @@
// Top level of the LED matrix BCM scan driver.
// Depends on lmbcm_pkg, lmbcm_front, lmbcm_queue, lmbcm_back (and lmbcm_ram below it).
//
// Drives a two-bank LED panel with binary code modulation from a 5-bit RGB frame store.
// After reset a clearing pass zeroes all 2**(clog2(ROW_PAIR_COUNT) + clog2(PANEL_COLUMNS))
// frame store addresses (2048 at the defaults) with s_axis_tready low; base_time
// writes are taken throughout. Input beats carry the opcode in tuser: a pixel write is applied
// by the back end while idle, a row-done or start beat yields a run of PANEL_COLUMNS output
// beats at one beat per cycle while the output is not stalled, paced by the single read port
// of each half-panel RAM. A run pops its command in the idle state before its first RAM read,
// so back-to-back runs leave a gap between them; the first beat of a run passes through the
// command queue, the pop, the RAM read and the output register. Transfer errors and writes
// outside the panel are dropped. A four-entry command queue lets the front accept new beats
// while a run is still streaming; a stalled output holds the run without losing a beat.
// Each run beat carries the plane bit of the top and bottom pixel of one column, plus the
// row that was just displayed and its output-enable time (weight * base_time, weights
// 1,2,4,8,12); a start run reports display_valid, shown_row and on_time as zero.
module led_matrix_bcm_scan_driver_core #(
    parameter int PANEL_COLUMNS  = lmbcm_pkg::PANEL_COLUMNS_DEF,
    parameter int ROW_PAIR_COUNT = lmbcm_pkg::ROW_PAIR_COUNT_DEF,
    parameter int PLANE_COUNT    = lmbcm_pkg::PLANE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: base_time
    input  logic                                i_cfg_wr_en,
    input  logic [lmbcm_pkg::BASE_W-1:0]        i_cfg_wr_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: pixel_x[5:0], pixel_y[11:6], red[16:12], green[21:17], blue[26:22], zero[31:27]
    input  logic [lmbcm_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [lmbcm_pkg::OPCODE_W-1:0]      i_s_axis_tuser,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: pins[5:0], column[11:6], shown_row[16:12], on_time[36:17], zero[39:37]
    output logic [lmbcm_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // tuser: display_valid[0]
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    logic            clearing;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    lmbcm_pkg::t_cmd push_cmd;
    lmbcm_pkg::t_cmd head_cmd;

    logic [lmbcm_pkg::PINS_W-1:0]    pins;
    logic [lmbcm_pkg::COL_FW-1:0]    column;
    logic [lmbcm_pkg::ROW_FW-1:0]    shown_row;
    logic [lmbcm_pkg::ON_TIME_W-1:0] on_time;

    // front: classify beats, track the scan position
    lmbcm_front #(
        .PANEL_COLUMNS  (PANEL_COLUMNS),
        .ROW_PAIR_COUNT (ROW_PAIR_COUNT),
        .PLANE_COUNT    (PLANE_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_opcode      (i_s_axis_tuser),
        .i_pixel_x     (i_s_axis_tdata[5:0]),
        .i_pixel_y     (i_s_axis_tdata[11:6]),
        .i_pixel       (i_s_axis_tdata[26:12]),
        .i_clearing    (clearing),
        .i_queue_full  (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    // commands stay in order so a later write never leaks into an earlier run
    lmbcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back: frame store and run sequencer
    lmbcm_back #(
        .PANEL_COLUMNS  (PANEL_COLUMNS),
        .ROW_PAIR_COUNT (ROW_PAIR_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (head_cmd),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_pins          (pins),
        .o_column        (column),
        .o_display_valid (o_m_axis_tuser),
        .o_shown_row     (shown_row),
        .o_on_time       (on_time),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, on_time, shown_row, column, pins};

endmodule
